/* src/prt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types, codes and sizes of the pending request table.
// ----------------------------------------------------------------------------
package prt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int ID_W      = 32;
  localparam int CLASS_W   = 8;
  localparam int HANDLER_W = 16;
  localparam int TIME_W    = 32;
  localparam int TMO_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int OUT_CNT_W = 5;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd120;
  localparam logic [CLASS_W-1:0] CLASS_NONE  = 8'd0;

  // commands
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FETCHED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // one table entry
  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [CLASS_W-1:0]   cls;
    logic [HANDLER_W-1:0] handler;
    logic [TIME_W-1:0]    stamp;
  } entry_t;

  // entry memory control
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_ctl_t;

  // compare unit flags
  typedef struct packed {
    logic expired;
    logic id_hit;
    logic class_hit;
  } match_t;

endpackage

/* src/prt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_if
// Valid/ready channels for requests into and results out of the table.
// ----------------------------------------------------------------------------
interface prt_req_if import prt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [ID_W-1:0]      request_id;
  logic [CLASS_W-1:0]   proc_class;
  logic [HANDLER_W-1:0] handler_tag;
  logic [TIME_W-1:0]    now_time;

  modport source (output valid, cmd, request_id, proc_class, handler_tag, now_time,
                  input ready);
  modport sink   (input valid, cmd, request_id, proc_class, handler_tag, now_time,
                  output ready);
endinterface

interface prt_rsp_if import prt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [HANDLER_W-1:0] handler_out;
  logic [OUT_CNT_W-1:0] expired_count;
  logic [OUT_CNT_W-1:0] entries_in_use;

  modport source (output valid, status, handler_out, expired_count, entries_in_use,
                  input ready);
  modport sink   (input valid, status, handler_out, expired_count, entries_in_use,
                  output ready);
endinterface

/* src/prt_entry_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_entry_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prt_entry_ram import prt_pkg::*; (
  input  logic     clk,
  input  ram_ctl_t ctl,
  input  entry_t   wdata,
  output entry_t   rdata
);

  entry_t mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[ctl.raddr];
    end
  end

endmodule

/* src/prt_match_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_match_unit
// Shared compare unit: entry age against timeout, id and class matches.
// ----------------------------------------------------------------------------
module prt_match_unit import prt_pkg::*; (
  input  entry_t               entry,
  input  logic [TIME_W-1:0]    now_time,
  input  logic [TMO_W-1:0]     timeout,
  input  logic [ID_W-1:0]      request_id,
  input  logic [CLASS_W-1:0]   proc_class,
  output match_t               flags
);

  logic [TIME_W-1:0] age;

  // age wraps modulo the time width
  assign age = now_time - entry.stamp;

  always_comb begin
    flags.expired   = age > TIME_W'(timeout);
    flags.id_hit    = entry.id == request_id;
    flags.class_hit = entry.cls == proc_class;
  end

endmodule

/* src/pending_request_table_core.sv */
`timescale 1ns / 1ps
// A transfer latches the request, the scan reads one entry per cycle into the compare unit,
// then the finish state loads the result register; an add of class none skips the scan.
// One operation at a time: the next transfer is taken in the cycle after the result loads,
// later while the previous result waits. Reset: table empties, timeout back to 120; stored
// entries stay undefined, no clearing pass is needed since only entries below the fill
// count are read.
// ----------------------------------------------------------------------------
// pending_request_table_core
// Ordered table of outstanding requests with in-place class replace, expiry
// and fetch by id, compacted in a single streaming pass over the entry store.
// ----------------------------------------------------------------------------
module pending_request_table_core import prt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             timeout_we,
  input  logic [TMO_W-1:0] timeout_wdata,
  prt_req_if.sink          req,
  prt_rsp_if.source        rsp
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]           state, state_next;
  logic [TMO_W-1:0]     timeout;
  logic [CNT_W-1:0]     used, used_next;
  logic [CNT_W-1:0]     rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]     eval_ptr, eval_ptr_next;
  logic [CNT_W-1:0]     wp, wp_next;
  logic [CNT_W-1:0]     expired, expired_next;
  logic [CNT_W-1:0]     hit_idx, hit_idx_next;
  logic                 vld, vld_next;
  logic                 found, found_next;
  logic [HANDLER_W-1:0] hit_handler, hit_handler_next;

  // latched request
  logic                 op_cmd;
  logic [ID_W-1:0]      op_id;
  logic [CLASS_W-1:0]   op_cls;
  logic [HANDLER_W-1:0] op_hnd;
  logic [TIME_W-1:0]    op_now;

  // result register
  logic                 out_valid, out_valid_next;
  logic [STATUS_W-1:0]  out_status, out_status_next;
  logic [HANDLER_W-1:0] out_handler, out_handler_next;
  logic [OUT_CNT_W-1:0] out_expired, out_expired_next;
  logic [OUT_CNT_W-1:0] out_used, out_used_next;

  ram_ctl_t ram_ctl;
  entry_t   ram_wdata;
  entry_t   ram_rdata;
  match_t   flags;
  logic     req_xfer;
  logic     out_free;

  prt_entry_ram u_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  prt_match_unit u_match (
    .entry      (ram_rdata),
    .now_time   (op_now),
    .timeout    (timeout),
    .request_id (op_id),
    .proc_class (op_cls),
    .flags      (flags)
  );

  assign req.ready          = state == S_IDLE;
  assign req_xfer           = req.valid && req.ready;
  assign out_free           = !out_valid || rsp.ready;
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.handler_out    = out_handler;
  assign rsp.expired_count  = out_expired;
  assign rsp.entries_in_use = out_used;

  // sequencer
  always_comb begin
    state_next       = state;
    used_next        = used;
    rd_ptr_next      = rd_ptr;
    eval_ptr_next    = eval_ptr;
    wp_next          = wp;
    expired_next     = expired;
    hit_idx_next     = hit_idx;
    vld_next         = 1'b0;
    found_next       = found;
    hit_handler_next = hit_handler;
    out_valid_next   = out_valid && !rsp.ready;
    out_status_next  = out_status;
    out_handler_next = out_handler;
    out_expired_next = out_expired;
    out_used_next    = out_used;
    ram_ctl          = '0;
    ram_wdata        = ram_rdata;

    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          rd_ptr_next   = '0;
          eval_ptr_next = '0;
          wp_next       = '0;
          expired_next  = '0;
          found_next    = 1'b0;
          if (req.cmd == CMD_ADD && req.proc_class == CLASS_NONE) begin
            state_next = S_FIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // evaluate the entry read last cycle
        if (vld) begin
          eval_ptr_next = eval_ptr + 1'b1;
          if (op_cmd == CMD_ADD) begin
            if (flags.class_hit) begin
              found_next   = 1'b1;
              hit_idx_next = eval_ptr;
            end
          end else if (flags.expired) begin
            expired_next = expired + 1'b1;
          end else if (!found && flags.id_hit) begin
            found_next       = 1'b1;
            hit_handler_next = ram_rdata.handler;
          end else begin
            // keep: compact down to the write pointer
            ram_ctl.we    = 1'b1;
            ram_ctl.waddr = wp[IDX_W-1:0];
            wp_next       = wp + 1'b1;
          end
        end
        // issue the next read or finish
        if (vld && op_cmd == CMD_ADD && flags.class_hit) begin
          state_next = S_FIN;
        end else if (rd_ptr < used) begin
          ram_ctl.re    = 1'b1;
          ram_ctl.raddr = rd_ptr[IDX_W-1:0];
          rd_ptr_next   = rd_ptr + 1'b1;
          vld_next      = 1'b1;
        end else if (!vld) begin
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          out_handler_next = '0;
          out_expired_next = '0;
          state_next       = S_IDLE;
          ram_wdata.id      = op_id;
          ram_wdata.cls     = op_cls;
          ram_wdata.handler = op_hnd;
          ram_wdata.stamp   = op_now;
          if (op_cmd == CMD_ADD) begin
            if (found) begin
              ram_ctl.we      = 1'b1;
              ram_ctl.waddr   = hit_idx[IDX_W-1:0];
              out_status_next = ST_REPLACED;
            end else if (used < CNT_W'(TABLE_DEPTH)) begin
              ram_ctl.we      = 1'b1;
              ram_ctl.waddr   = used[IDX_W-1:0];
              used_next       = used + 1'b1;
              out_status_next = ST_APPENDED;
            end else begin
              out_status_next = ST_FULL;
            end
          end else begin
            used_next        = wp;
            out_expired_next = OUT_CNT_W'(expired);
            if (found) begin
              out_status_next  = ST_FETCHED;
              out_handler_next = hit_handler;
            end else begin
              out_status_next = ST_NOTFOUND;
            end
          end
          out_used_next = OUT_CNT_W'(used_next);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      vld       <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
      timeout   <= TIMEOUT_RESET;
    end else begin
      state     <= state_next;
      used      <= used_next;
      vld       <= vld_next;
      found     <= found_next;
      out_valid <= out_valid_next;
      if (timeout_we) begin
        timeout <= timeout_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_ptr      <= rd_ptr_next;
    eval_ptr    <= eval_ptr_next;
    wp          <= wp_next;
    expired     <= expired_next;
    hit_idx     <= hit_idx_next;
    hit_handler <= hit_handler_next;
    out_status  <= out_status_next;
    out_handler <= out_handler_next;
    out_expired <= out_expired_next;
    out_used    <= out_used_next;
    if (req_xfer) begin
      op_cmd <= req.cmd;
      op_id  <= req.request_id;
      op_cls <= req.proc_class;
      op_hnd <= req.handler_tag;
      op_now <= req.now_time;
    end
  end

`ifndef NO_ASSERTIONS
  // fill count never passes the table depth
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  // compaction writes never overtake the entry under evaluation
  a_wp_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && vld) |-> (wp <= eval_ptr))
    else $error("compaction pointer passed scan pointer");

  // reads stay inside the filled part of the table
  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (rd_ptr <= used))
    else $error("scan read beyond fill count");

  // an add result carries no handler and no expiry count
  a_add_result: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_APPENDED || rsp.status == ST_REPLACED ||
                   rsp.status == ST_FULL))
      |-> (rsp.handler_out == '0 && rsp.expired_count == '0))
    else $error("add result with fetch fields set");
`endif

endmodule

/* dv/tb_pending_request_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pending_request_table_core
// Self-checking bench for the pending request table. Requests go in through
// a valid/ready driver and results come out through a monitor with random
// back-pressure. A behavioral copy of the table predicts every result, and
// results are compared in order. The run steps through several timeout
// settings, including zero and the largest value.
// ----------------------------------------------------------------------------
module tb_pending_request_table_core;
  import prt_pkg::*;

  localparam int ITEMS_PER_PHASE = 80;
  localparam int MAX_WAIT        = 10;
  localparam int LONG_HOLD       = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = TABLE_DEPTH + 8;
  localparam int MAX_REPORTS     = 10;
  localparam int POOL_DEPTH      = 24;
  localparam int NUM_STATUS      = 5;

  // one request as it goes over the request channel
  typedef struct packed {
    logic                 cmd;
    logic [ID_W-1:0]      request_id;
    logic [CLASS_W-1:0]   proc_class;
    logic [HANDLER_W-1:0] handler_tag;
    logic [TIME_W-1:0]    now_time;
  } op_t;

  // one result as it comes off the result channel
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [HANDLER_W-1:0] handler_out;
    logic [OUT_CNT_W-1:0] expired_count;
    logic [OUT_CNT_W-1:0] entries_in_use;
  } outcome_t;

  // clock, reset and configuration port
  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             timeout_we    = 1'b0;
  logic [TMO_W-1:0] timeout_wdata = '0;

  always #5 clk = ~clk;

  // channels
  prt_req_if req_ch ();
  prt_rsp_if rsp_ch ();

  logic drv_valid  = 1'b0;
  op_t  drv_op     = '0;
  logic sink_ready = 1'b0;

  assign req_ch.valid       = drv_valid;
  assign req_ch.cmd         = drv_op.cmd;
  assign req_ch.request_id  = drv_op.request_id;
  assign req_ch.proc_class  = drv_op.proc_class;
  assign req_ch.handler_tag = drv_op.handler_tag;
  assign req_ch.now_time    = drv_op.now_time;
  assign rsp_ch.ready       = sink_ready;

  pending_request_table_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .timeout_we    (timeout_we),
    .timeout_wdata (timeout_wdata),
    .req           (req_ch),
    .rsp           (rsp_ch)
  );

  // shadow copy of the table
  entry_t           tbl [TABLE_DEPTH];
  int               fill      = 0;
  logic [TMO_W-1:0] tmo_model = TIMEOUT_RESET;

  // request backlog and results still owed by the block
  op_t      req_backlog[$];
  outcome_t expected_outcomes[$];

  int errors        = 0;
  int reports       = 0;
  int ops_sent      = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int status_hits [NUM_STATUS];

  // flow control shared between stimulus, driver and monitor
  logic burst_mode    = 1'b0;
  logic sender_hold   = 1'b0;
  int   hold_requests = 0;

  // generator state
  logic [ID_W-1:0]   id_pool[$];
  logic [TIME_W-1:0] gen_now  = '0;
  int                step_max = 40;

  function automatic int draw_wait();
    return burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // apply one operation to the shadow table and return what the block owes
  function automatic outcome_t table_apply(op_t op);
    outcome_t          r;
    int                pos;
    int                k;
    int                kept;
    logic [TIME_W-1:0] age;
    r = '0;
    if (op.cmd == CMD_ADD) begin
      // class none always appends, any other class looks for a slot to reuse
      pos = fill;
      if (op.proc_class != CLASS_NONE) begin
        pos = 0;
        while (pos < fill && tbl[pos].cls != op.proc_class) pos++;
      end
      if (pos < fill) begin
        r.status = ST_REPLACED;
      end else if (fill >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = fill;
        fill++;
        r.status = ST_APPENDED;
      end
      if (r.status != ST_FULL) begin
        tbl[pos].id      = op.request_id;
        tbl[pos].cls     = op.proc_class;
        tbl[pos].handler = op.handler_tag;
        tbl[pos].stamp   = op.now_time;
      end
    end else begin
      // expire old entries, keeping order of the survivors
      kept = 0;
      for (k = 0; k < fill; k++) begin
        age = op.now_time - tbl[k].stamp;
        if (age > TIME_W'(tmo_model)) begin
          r.expired_count++;
        end else begin
          tbl[kept] = tbl[k];
          kept++;
        end
      end
      fill = kept;
      // first matching id wins
      pos = 0;
      while (pos < fill && tbl[pos].id != op.request_id) pos++;
      if (pos < fill) begin
        r.status      = ST_FETCHED;
        r.handler_out = tbl[pos].handler;
        for (k = pos; k + 1 < fill; k++) tbl[k] = tbl[k + 1];
        fill--;
      end else begin
        r.status = ST_NOTFOUND;
      end
    end
    r.entries_in_use = OUT_CNT_W'(fill);
    return r;
  endfunction

  function automatic op_t mk_op(logic c, logic [ID_W-1:0] id, logic [CLASS_W-1:0] cls,
                                logic [HANDLER_W-1:0] hnd, logic [TIME_W-1:0] now);
    op_t op;
    op.cmd         = c;
    op.request_id  = id;
    op.proc_class  = cls;
    op.handler_tag = hnd;
    op.now_time    = now;
    return op;
  endfunction

  // mostly class none or a handful of small classes so that replaces happen
  function automatic logic [CLASS_W-1:0] pick_class();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return CLASS_NONE;
    if (sel < 85) return CLASS_W'($urandom_range(1, 6));
    return CLASS_W'($urandom_range(0, 255));
  endfunction

  // ids for adds: mostly fresh, some reused to get duplicates
  function automatic logic [ID_W-1:0] pick_add_id();
    logic [ID_W-1:0] id;
    if (id_pool.size() == 0 || $urandom_range(0, 99) < 70) begin
      id = $urandom();
      id_pool.push_back(id);
      if (id_pool.size() > POOL_DEPTH) void'(id_pool.pop_front());
    end else begin
      id = id_pool[$urandom_range(0, id_pool.size() - 1)];
    end
    return id;
  endfunction

  // ids for fetches: mostly known ids, the rest misses
  function automatic logic [ID_W-1:0] pick_fetch_id();
    if (id_pool.size() != 0 && $urandom_range(0, 99) < 75)
      return id_pool[$urandom_range(0, id_pool.size() - 1)];
    return $urandom();
  endfunction

  // random traffic with an advancing clock, rare jumps and fill bursts
  task automatic gen_random(input int count);
    int j;
    int sel;
    for (j = 0; j < count; j++) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        // run of class-none adds at one time stamp to hit the full table
        repeat (TABLE_DEPTH + 2)
          req_backlog.push_back(mk_op(CMD_ADD, pick_add_id(), CLASS_NONE,
                                      HANDLER_W'($urandom()), gen_now));
      end else begin
        if ($urandom_range(0, 49) == 0) gen_now = $urandom();
        else gen_now = gen_now + TIME_W'($urandom_range(0, step_max));
        if (sel < 58)
          req_backlog.push_back(mk_op(CMD_ADD, pick_add_id(), pick_class(),
                                      HANDLER_W'($urandom()), gen_now));
        else
          req_backlog.push_back(mk_op(CMD_FETCH, pick_fetch_id(), CLASS_W'($urandom()),
                                      HANDLER_W'($urandom()), gen_now));
      end
    end
  endtask

  task automatic write_timeout(input logic [TMO_W-1:0] value);
    @(posedge clk);
    timeout_we    <= 1'b1;
    timeout_wdata <= value;
    @(posedge clk);
    timeout_we <= 1'b0;
    tmo_model = value;
    settings_used++;
  endtask

  task automatic wait_idle();
    while (req_backlog.size() != 0 || drv_valid || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : driver
    int gap_left;
    if (rst) begin
      drv_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (drv_valid && req_ch.ready) begin
        expected_outcomes.push_back(table_apply(drv_op));
        ops_sent++;
        gap_left = draw_wait();
      end
      if (drv_valid && !req_ch.ready) begin
        // hold the offered request
      end else if (gap_left > 0) begin
        gap_left--;
        drv_valid <= 1'b0;
      end else if (req_backlog.size() != 0 && !sender_hold) begin
        drv_op    <= req_backlog.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // result monitor with random and long back-pressure
  always @(posedge clk) begin : monitor
    outcome_t got;
    outcome_t want;
    int       stall_left;
    int       long_left;
    int       holds_seen;
    if (rst) begin
      sink_ready <= 1'b0;
      stall_left = 0;
      long_left  = 0;
      holds_seen = 0;
    end else begin
      if (rsp_ch.valid && sink_ready) begin
        got.status         = rsp_ch.status;
        got.handler_out    = rsp_ch.handler_out;
        got.expired_count  = rsp_ch.expired_count;
        got.entries_in_use = rsp_ch.entries_in_use;
        results_seen++;
        if (expected_outcomes.size() == 0) begin
          errors++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("[%0t] result with nothing expected: status %0d handler %h exp %0d used %0d",
                     $realtime, got.status, got.handler_out, got.expired_count,
                     got.entries_in_use);
          end
        end else begin
          want = expected_outcomes.pop_front();
          if (want.status < NUM_STATUS) status_hits[want.status]++;
          if (got.status !== want.status || got.handler_out !== want.handler_out ||
              got.expired_count !== want.expired_count ||
              got.entries_in_use !== want.entries_in_use) begin
            errors++;
            if (reports < MAX_REPORTS) begin
              reports++;
              $display("[%0t] result %0d mismatch: expected status %0d handler %h exp %0d used %0d",
                       $realtime, results_seen, want.status, want.handler_out,
                       want.expired_count, want.entries_in_use);
              $display("[%0t]   actual status %0d handler %h exp %0d used %0d",
                       $realtime, got.status, got.handler_out, got.expired_count,
                       got.entries_in_use);
            end
          end
        end
        stall_left = draw_wait();
      end
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        long_left  = LONG_HOLD;
      end
      if (long_left > 0) begin
        long_left--;
        sink_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((drv_valid && req_ch.ready) || (rsp_ch.valid && sink_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("tb_pending_request_table_core: FAIL");
        $finish;
      end
    end
  end

  // stimulus and phase sequencing
  initial begin : stimulus
    logic [TMO_W-1:0] tmo_plan [5];
    int               p;
    int               k;
    for (k = 0; k < NUM_STATUS; k++) status_hits[k] = 0;
    tmo_plan[0] = '0;
    tmo_plan[1] = '1;
    tmo_plan[2] = TMO_W'($urandom_range(1, 65534));
    tmo_plan[3] = TMO_W'(1);
    tmo_plan[4] = TIMEOUT_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part, timeout at its reset value
    // fetch on an empty table
    req_backlog.push_back(mk_op(CMD_FETCH, '0, CLASS_NONE, '0, '0));
    // duplicate ids with class none, extreme fields
    req_backlog.push_back(mk_op(CMD_ADD, '1, CLASS_NONE, '1, '0));
    req_backlog.push_back(mk_op(CMD_ADD, '1, CLASS_NONE, 16'h1234, 32'd1));
    // same class twice: second one replaces in place
    req_backlog.push_back(mk_op(CMD_ADD, 32'd5, 8'hFF, '0, 32'd2));
    req_backlog.push_back(mk_op(CMD_ADD, 32'd6, 8'hFF, 16'hAAAA, 32'd3));
    // first of the duplicates goes first
    req_backlog.push_back(mk_op(CMD_FETCH, '1, CLASS_NONE, '0, 32'd10));
    // age equal to the timeout survives
    req_backlog.push_back(mk_op(CMD_FETCH, '1, CLASS_NONE, '0, 32'd121));
    // age one past the timeout expires, leaving a miss
    req_backlog.push_back(mk_op(CMD_FETCH, 32'd6, CLASS_NONE, '0, 32'd124));
    // fill the table, one entry with a class of its own
    for (k = 0; k < TABLE_DEPTH; k++)
      req_backlog.push_back(mk_op(CMD_ADD, ID_W'(k), (k == 9) ? CLASS_W'(7) : CLASS_NONE,
                                  HANDLER_W'(k * 4099), 32'd200));
    // append to a full table is refused, replace still works
    req_backlog.push_back(mk_op(CMD_ADD, 32'd77, CLASS_NONE, 16'h5555, 32'd201));
    req_backlog.push_back(mk_op(CMD_ADD, 32'd78, CLASS_W'(7), 16'h0F0F, 32'd202));
    // time behind every stamp: wrapped age expires the whole table
    req_backlog.push_back(mk_op(CMD_FETCH, 32'd3, CLASS_NONE, '0, 32'd150));
    wait_idle();

    // random phases over several timeout settings
    for (p = 0; p < 5; p++) begin
      write_timeout(tmo_plan[p]);
      step_max   = int'(tmo_plan[p]) / 3 + 1;
      burst_mode = (p == 0);
      gen_now    = $urandom();
      gen_random(ITEMS_PER_PHASE);
      if (p == 2) begin
        // long receiver hold-off while requests keep coming
        while (req_backlog.size() > 60) @(posedge clk);
        @(posedge clk);
        hold_requests <= hold_requests + 1;
        // then the sender stops until every result is back
        while (req_backlog.size() > 30) @(posedge clk);
        @(posedge clk);
        sender_hold <= 1'b1;
        while (drv_valid || expected_outcomes.size() != 0) @(posedge clk);
        repeat (MAX_WAIT) @(posedge clk);
        sender_hold <= 1'b0;
      end
      wait_idle();
    end

    errors += expected_outcomes.size();
    $display("run covered %0d operations and %0d results over %0d timeout settings",
             ops_sent, results_seen, settings_used + 1);
    $display("results by status: appended %0d replaced %0d full %0d fetched %0d missed %0d",
             status_hits[ST_APPENDED], status_hits[ST_REPLACED], status_hits[ST_FULL],
             status_hits[ST_FETCHED], status_hits[ST_NOTFOUND]);
    if (errors == 0) begin
      $display("tb_pending_request_table_core: PASS");
    end else begin
      $display("%0d errors", errors);
      $display("tb_pending_request_table_core: FAIL");
    end
    $finish;
  end

endmodule

/* pending_request_table_core.f */
src/prt_pkg.sv
src/prt_if.sv
src/prt_entry_ram.sv
src/prt_match_unit.sv
src/pending_request_table_core.sv
dv/tb_pending_request_table_core.sv
